[rtl/elevation_step_drop_window_top_macros.svh]
// Assertion macros for the step and drop window block
`ifndef ELEVATION_STEP_DROP_WINDOW_TOP_MACROS_SVH
`define ELEVATION_STEP_DROP_WINDOW_TOP_MACROS_SVH
// implication checked on every clock, off during reset
`define ESD_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("%m: check failed");
// next-cycle implication
`define ESD_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("%m: check failed");
`endif

[rtl/esdw_pkg.sv]
// Shared types and constants for the step and drop window block
package esdw_pkg;
	localparam int ELEV_W = 16;
	localparam int LIMIT_W = 15;
	localparam int RSQ_W = 7;
	localparam int COORD_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_LIMIT = 2'd2;
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_EVAL = 1'b1;
endpackage

[rtl/esdw_ram.sv]
// Generic single-port RAM with registered read
module esdw_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16384,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/esdw_div.sv]
// Restoring divider producing a saturated fixed-point ratio
module esdw_div import esdw_pkg::*; #(
	parameter int FRAC_BITS = 12,
	localparam int RW = FRAC_BITS + 1,
	localparam int DW = ELEV_W + 1,
	localparam int NW = DW + FRAC_BITS,
	localparam int CW = $clog2(NW + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DW-1:0]      diff,
	input  logic [LIMIT_W-1:0] limit,
	output logic               done,
	output logic [RW-1:0]      ratio
);
	logic [NW-1:0]      num_q;
	logic [NW-1:0]      quo_q;
	logic [LIMIT_W:0]   rem_q;
	logic [LIMIT_W-1:0] den_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [LIMIT_W+1:0] trial;
	logic [LIMIT_W+1:0] shifted;

	assign shifted = {rem_q, num_q[NW-1]};
	assign trial = shifted - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {diff, {FRAC_BITS{1'b0}}};
			den_q <= (limit == '0) ? LIMIT_W'(1) : limit;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (!trial[LIMIT_W+1]) begin
				rem_q <= trial[LIMIT_W:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[LIMIT_W:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	// saturate at 1.0
	assign ratio = (quo_q > NW'(1 << FRAC_BITS)) ? RW'(1 << FRAC_BITS) : quo_q[RW-1:0];
endmodule

[rtl/elevation_step_drop_window_top.sv]
// Top level: grid store, window scan sequencer and ratio dividers
// Usage:
//  Input channel (in_valid/in_ready) carries kind, row, col, elevation and
//  elevation_valid. A write transfer stores one cell; it produces no result
//  and the block is ready again once the S_WRITE state has passed.
//  An evaluate transfer yields one result on the output channel
//  (out_valid/out_ready). The scan reads the centre, then every offset of the
//  (2*MAX_RADIUS+1)^2 square, one memory read per cycle from the single
//  grid RAM port, then waits in S_DRAIN for the last reads to return.
//  Both ratios then divide in parallel, and the S_HOLD state moves the
//  result to the output register. Invalid-centre evaluations finish after
//  the centre read.
//  One item is in work at a time. The finished result sits in an output
//  register; the next input is accepted while it waits, but a new result is
//  not produced until the previous one has been taken.
//  Reset clears control state and sets radius_squared=1, limits=10. The grid
//  has no reset; every evaluated window must be written first.
//  Configuration writes (cfg_we, cfg_index, cfg_data) apply at once and
//  should be issued only while the block is idle.
module elevation_step_drop_window_top import esdw_pkg::*; #(
	parameter int GRID_ROWS = 128,
	parameter int GRID_COLS = 128,
	parameter int MAX_RADIUS = 8,
	parameter int RATIO_FRAC_BITS = 12,
	localparam int RW = RATIO_FRAC_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [COORD_W-1:0]    row,
	input  logic [COORD_W-1:0]    col,
	input  logic signed [ELEV_W-1:0] elevation,
	input  logic                  elevation_valid,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_W-1:0]    out_row,
	output logic [COORD_W-1:0]    out_col,
	output logic [RW-1:0]         step_ratio,
	output logic [RW-1:0]         drop_ratio,
	output logic                  result_valid
);
	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam int AW = $clog2(CELLS);
	localparam int RB = $clog2(GRID_ROWS + 1) + 1;
	localparam int CB = $clog2(GRID_COLS + 1) + 1;
	localparam int OW = $clog2(2 * MAX_RADIUS + 1) + 1;
	localparam int SQW = 2 * OW;
	localparam int DW = ELEV_W + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_WRITE, S_CENTRE, S_SCAN, S_DRAIN, S_DIV, S_HOLD
	} state_t;

	state_t state_q;
	logic [RSQ_W-1:0]   rsq_q;
	logic [LIMIT_W-1:0] step_lim_q, drop_lim_q;
	logic               ev_q;
	logic [COORD_W-1:0] row_q, col_q;
	logic signed [ELEV_W-1:0] elev_q;
	logic signed [ELEV_W-1:0] zc_q, zmin_q, zmax_q;
	logic signed [OW-1:0] dr_q, dc_q;
	logic               rd_s1, rd_s2;
	logic               out_valid_q, res_valid_q;
	logic [COORD_W-1:0] out_row_q, out_col_q;
	logic [RW-1:0]      step_q, drop_q;
	logic [RW-1:0]      out_step_q, out_drop_q;
	logic               out_res_q;
	logic               div_start;
	logic               s_done, d_done;
	logic [RW-1:0]      s_ratio, d_ratio;

	// memory port
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [ELEV_W:0]    mem_rdata;
	logic signed [RB-1:0] r_abs;
	logic signed [CB-1:0] c_abs;
	logic [SQW-1:0]     win_sq;
	logic               in_win, in_grid, centre_in;
	logic signed [ELEV_W-1:0] rz;

	assign centre_in = (32'(row_q) < GRID_ROWS) && (32'(col_q) < GRID_COLS);
	assign r_abs = $signed({1'b0, (RB-1)'(row_q)}) + RB'(dr_q);
	assign c_abs = $signed({1'b0, (CB-1)'(col_q)}) + CB'(dc_q);
	assign win_sq = SQW'(dr_q) * SQW'(dr_q) + SQW'(dc_q) * SQW'(dc_q);
	assign in_win = win_sq <= SQW'(rsq_q);
	assign in_grid = (r_abs >= 0) && (r_abs < RB'(GRID_ROWS)) &&
		(c_abs >= 0) && (c_abs < CB'(GRID_COLS));

	always_comb begin
		mem_we = 1'b0;
		mem_addr = AW'(32'(row_q) * GRID_COLS + 32'(col_q));
		if (state_q == S_WRITE) begin
			mem_we = centre_in;
		end else if (state_q == S_SCAN) begin
			mem_addr = AW'(32'(r_abs) * GRID_COLS + 32'(c_abs));
		end
	end

	esdw_ram #(.WIDTH(ELEV_W + 1), .DEPTH(CELLS)) u_grid (
		.clk(clk), .we(mem_we), .addr(mem_addr),
		.wdata({ev_q, elev_q}), .rdata(mem_rdata)
	);

	assign rz = $signed(mem_rdata[ELEV_W-1:0]);
	assign div_start = (state_q == S_DRAIN) && !rd_s1 && !rd_s2;

	esdw_div #(.FRAC_BITS(RATIO_FRAC_BITS)) u_sdiv (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.diff(DW'(zmax_q) - DW'(zc_q)), .limit(step_lim_q),
		.done(s_done), .ratio(s_ratio)
	);
	esdw_div #(.FRAC_BITS(RATIO_FRAC_BITS)) u_ddiv (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.diff(DW'(zc_q) - DW'(zmin_q)), .limit(drop_lim_q),
		.done(d_done), .ratio(d_ratio)
	);

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsq_q <= RSQ_W'(1);
			step_lim_q <= LIMIT_W'(10);
			drop_lim_q <= LIMIT_W'(10);
			out_valid_q <= 1'b0;
			rd_s1 <= 1'b0;
			rd_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RADIUS_SQ: rsq_q <= cfg_data[RSQ_W-1:0];
					CFG_STEP_LIMIT: step_lim_q <= cfg_data[LIMIT_W-1:0];
					CFG_DROP_LIMIT: drop_lim_q <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// read pipeline: rd_s1 = data of a counted read present, rd_s2 = rd_s1 registered again
			rd_s1 <= (state_q == S_SCAN) && in_win && in_grid;
			rd_s2 <= rd_s1;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (kind == KIND_WRITE) ? S_WRITE : S_CENTRE;
					end
				end
				S_WRITE: state_q <= S_IDLE;
				S_CENTRE: begin
					// centre address issued in this cycle; data next cycle
					dr_q <= -OW'(MAX_RADIUS);
					dc_q <= -OW'(MAX_RADIUS);
					state_q <= S_SCAN;
					if (!centre_in) begin
						state_q <= S_HOLD;
						res_valid_q <= 1'b0;
						step_q <= '0;
						drop_q <= '0;
					end
				end
				S_SCAN: begin
					if (dc_q == OW'(MAX_RADIUS)) begin
						dc_q <= -OW'(MAX_RADIUS);
						dr_q <= dr_q + 1'b1;
						if (dr_q == OW'(MAX_RADIUS)) begin
							state_q <= S_DRAIN;
						end
					end else begin
						dc_q <= dc_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (div_start) state_q <= S_DIV;
				end
				S_DIV: begin
					if (s_done && d_done) begin
						step_q <= s_ratio;
						drop_q <= d_ratio;
						res_valid_q <= 1'b1;
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_row_q <= row_q;
						out_col_q <= col_q;
						out_step_q <= step_q;
						out_drop_q <= drop_q;
						out_res_q <= res_valid_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// first scan cycle sees the centre word
			if (state_q == S_SCAN && dr_q == -OW'(MAX_RADIUS) &&
					dc_q == -OW'(MAX_RADIUS)) begin
				zc_q <= rz;
				zmin_q <= rz;
				zmax_q <= rz;
				if (!mem_rdata[ELEV_W]) begin
					state_q <= S_HOLD;
					res_valid_q <= 1'b0;
					step_q <= '0;
					drop_q <= '0;
				end
			end else if (rd_s1 && mem_rdata[ELEV_W]) begin
				if (rz < zmin_q) zmin_q <= rz;
				if (rz > zmax_q) zmax_q <= rz;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			row_q <= row;
			col_q <= col;
			elev_q <= elevation;
			ev_q <= elevation_valid;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign step_ratio = out_step_q;
	assign drop_ratio = out_drop_q;
	assign result_valid = out_res_q;
endmodule

[rtl/esdw_checker.sv]
// Port-level checker for the step and drop window block, with bind
`include "elevation_step_drop_window_top_macros.svh"
module esdw_checker import esdw_pkg::*; #(
	parameter int RW = 13
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic [RW-1:0] step_ratio,
	input logic [RW-1:0] drop_ratio,
	input logic          result_valid
);
	`ESD_ASSERT_IMP(a_step_sat, clk, arst_n, out_valid, step_ratio <= RW'(1 << (RW - 1)))
	`ESD_ASSERT_IMP(a_drop_sat, clk, arst_n, out_valid, drop_ratio <= RW'(1 << (RW - 1)))
	`ESD_ASSERT_IMP(a_inv_zero, clk, arst_n, out_valid && !result_valid,
		step_ratio == '0 && drop_ratio == '0)
	`ESD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ESD_ASSERT_NXT(a_one_busy, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind elevation_step_drop_window_top esdw_checker #(.RW(RATIO_FRAC_BITS + 1)) u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .step_ratio(step_ratio),
	.drop_ratio(drop_ratio), .result_valid(result_valid)
);

[tb/sv/elevation_step_drop_window_top_tb.sv]
// Testbench for the elevation step/drop window block: self-checking, random and directed
`timescale 1ns / 100ps

module elevation_step_drop_window_top_tb;
	import esdw_pkg::*;

	localparam int ROWS = 128;
	localparam int COLS = 128;
	localparam int WIN = 8;            // MAX_RADIUS of the block
	localparam int REG = 20;           // side of each written corner patch
	localparam int FRAC = 12;
	localparam int RW = FRAC + 1;
	localparam int EVAL_LATENCY = 400; // idle wait before the final result check
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [COORD_W-1:0] r;
		logic [COORD_W-1:0] c;
		logic [RW-1:0]      step;
		logic [RW-1:0]      drop;
		logic               known;
	} window_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] col;
	logic signed [ELEV_W-1:0] elevation;
	logic elevation_valid;
	logic out_valid;
	logic out_ready;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic [RW-1:0] step_ratio;
	logic [RW-1:0] drop_ratio;
	logic result_valid;

	elevation_step_drop_window_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.row(row),
		.col(col),
		.elevation(elevation),
		.elevation_valid(elevation_valid),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_row(out_row),
		.out_col(out_col),
		.step_ratio(step_ratio),
		.drop_ratio(drop_ratio),
		.result_valid(result_valid)
	);

	// Shadow of the grid and of the registers
	logic signed [ELEV_W-1:0] grid_height [ROWS*COLS];
	logic grid_known [ROWS*COLS];
	logic [RSQ_W-1:0] shadow_rsq;
	logic [LIMIT_W-1:0] shadow_step_lim;
	logic [LIMIT_W-1:0] shadow_drop_lim;

	window_result_t pending_results[$];
	int errors;
	longint cycles;

	// Sender burst state
	int burst_left;
	bit sender_steady;     // when set, no gaps between transfers

	// Receiver control
	int hold_left;         // long hold-off requested by a test, counted by the receiver
	int stall_mode;
	int mode_left;
	int stall_phase;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("elevation_step_drop_window_top test failed");
			$finish;
		end
	end

	// Ratio = floor(diff * 2^F / limit), saturated at 1.0; limit 0 acts as 1
	function automatic logic [RW-1:0] ratio_q12(input longint diff, input longint lim);
		longint q;
		if (lim == 0)
			lim = 1;
		q = (diff << FRAC) / lim;
		if (q > (64'sd1 << FRAC))
			q = 64'sd1 << FRAC;
		return q[RW-1:0];
	endfunction

	// Min/max over the circular window, clipped to the grid and to the max radius
	function automatic window_result_t predict_window(input int r, input int c);
		window_result_t res;
		int zc, zmin, zmax, rr, cc, idx;
		res.r = COORD_W'(r);
		res.c = COORD_W'(c);
		res.step = '0;
		res.drop = '0;
		res.known = 1'b0;
		if (!grid_known[r*COLS+c])
			return res;
		zc = grid_height[r*COLS+c];
		zmin = zc;
		zmax = zc;
		for (int dr = -WIN; dr <= WIN; dr++) begin
			for (int dc = -WIN; dc <= WIN; dc++) begin
				rr = r + dr;
				cc = c + dc;
				if (dr*dr + dc*dc > int'(shadow_rsq))
					continue;
				if (rr < 0 || rr >= ROWS || cc < 0 || cc >= COLS)
					continue;
				idx = rr*COLS + cc;
				if (!grid_known[idx])
					continue;
				if (grid_height[idx] < zmin) zmin = grid_height[idx];
				if (grid_height[idx] > zmax) zmax = grid_height[idx];
			end
		end
		res.step = ratio_q12(zmax - zc, shadow_step_lim);
		res.drop = ratio_q12(zc - zmin, shadow_drop_lim);
		res.known = 1'b1;
		return res;
	endfunction

	// Centre whose whole window lies inside one written corner patch
	function automatic void pick_centre(output int r, output int c);
		if ($urandom_range(0, 1) == 0) begin
			r = $urandom_range(0, REG-1-WIN);
			c = $urandom_range(0, REG-1-WIN);
		end else begin
			r = $urandom_range(ROWS-REG+WIN, ROWS-1);
			c = $urandom_range(COLS-REG+WIN, COLS-1);
		end
	endfunction

	// Any cell of a corner patch
	function automatic void pick_cell(output int r, output int c);
		if ($urandom_range(0, 1) == 0) begin
			r = $urandom_range(0, REG-1);
			c = $urandom_range(0, REG-1);
		end else begin
			r = $urandom_range(ROWS-REG, ROWS-1);
			c = $urandom_range(COLS-REG, COLS-1);
		end
	endfunction

	// One input transfer; called right after a rising edge
	task automatic send_item(input logic k, input int r, input int c,
			input logic signed [ELEV_W-1:0] z, input logic zv);
		int gap;
		if (burst_left <= 0) begin
			gap = sender_steady ? 0 : $urandom_range(0, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		row <= COORD_W'(r);
		col <= COORD_W'(c);
		elevation <= z;
		elevation_valid <= zv;
		do @(posedge clk); while (!in_ready);
		// transfer happened at this edge: update the shadow model
		if (k == KIND_WRITE) begin
			grid_height[r*COLS+c] = z;
			grid_known[r*COLS+c] = zv;
		end else begin
			pending_results.push_back(predict_window(r, c));
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// a trailing write may still be in work
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RADIUS_SQ: begin
				shadow_rsq = RSQ_W'(val);
			end
			CFG_STEP_LIMIT: begin
				shadow_step_lim = LIMIT_W'(val);
			end
			CFG_DROP_LIMIT: begin
				shadow_drop_lim = LIMIT_W'(val);
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input int rsq, input int sl, input int dl);
		write_reg(CFG_RADIUS_SQ, rsq);
		write_reg(CFG_STEP_LIMIT, sl);
		write_reg(CFG_DROP_LIMIT, dl);
	endtask

	// Terrain-like height: a gentle slope plus noise, sometimes a wild value
	function automatic logic signed [ELEV_W-1:0] terrain_height(input int r, input int c);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 4)
			return ELEV_W'($urandom());
		return ELEV_W'(((r*37 + c*11) % 400) - 200 + int'($urandom_range(0, 60)) - 30);
	endfunction

	function automatic logic terrain_known();
		return $urandom_range(0, 9) != 0;
	endfunction

	// Both corner patches are written before any evaluation reads them
	task automatic test_fill_grid();
		sender_steady = 1'b0;
		for (int r = 0; r < REG; r++)
			for (int c = 0; c < REG; c++) begin
				send_item(KIND_WRITE, r, c, terrain_height(r, c), terrain_known());
				send_item(KIND_WRITE, ROWS-REG+r, COLS-REG+c,
					terrain_height(ROWS-REG+r, COLS-REG+c), terrain_known());
			end
	endtask

	task automatic test_directed();
		// corners and edges with reset registers
		send_item(KIND_EVAL, 0, 0, 16'sd0, 1'b0);
		send_item(KIND_EVAL, ROWS-1, COLS-1, 16'sd0, 1'b0);
		send_item(KIND_EVAL, 0, REG-1-WIN, 16'sd0, 1'b0);
		send_item(KIND_EVAL, ROWS-REG+WIN, COLS-1, 16'sd0, 1'b0);
		// unknown centre
		send_item(KIND_WRITE, 5, 5, 16'sd1234, 1'b0);
		send_item(KIND_EVAL, 5, 5, 16'sd0, 1'b0);
		// extreme heights side by side: full-range step and drop, saturated
		send_item(KIND_WRITE, 6, 6, 16'sh8000, 1'b1);
		send_item(KIND_WRITE, 6, 7, 16'sh7fff, 1'b1);
		send_item(KIND_WRITE, 7, 6, 16'sh7fff, 1'b1);
		send_item(KIND_EVAL, 6, 6, 16'sd0, 1'b0);
		send_item(KIND_EVAL, 6, 7, 16'sd0, 1'b0);
		// zero radius: centre only
		set_config(0, 1, 1);
		send_item(KIND_EVAL, 6, 6, 16'sd0, 1'b0);
		send_item(KIND_EVAL, 6, 7, 16'sd0, 1'b0);
		// radius beyond the max window, largest limits
		set_config(127, 32767, 32767);
		send_item(KIND_EVAL, 6, 6, 16'sd0, 1'b0);
		send_item(KIND_EVAL, 120, 120, 16'sd0, 1'b0);
		send_item(KIND_EVAL, 0, 0, 16'sd0, 1'b0);
		// zero limits act as one
		set_config(64, 0, 0);
		send_item(KIND_EVAL, 6, 7, 16'sd0, 1'b0);
		send_item(KIND_EVAL, 118, 125, 16'sd0, 1'b0);
	endtask

	// Long receiver hold-off while evaluations keep coming: input must stall
	task automatic test_backpressure();
		int r, c;
		set_config(8, 50, 50);
		hold_left = 3000;
		sender_steady = 1'b1;
		for (int i = 0; i < 8; i++) begin
			pick_centre(r, c);
			send_item(KIND_EVAL, r, c, 16'sd0, 1'b0);
		end
		sender_steady = 1'b0;
		// pause until all results are back, then go on
		wait_drained();
	endtask

	task automatic test_random();
		int rsq_pick [6] = '{0, 1, 2, 13, 64, 127};
		int r, c;
		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(0, 3))
				0: set_config(rsq_pick[ph], 1, 32767);
				1: set_config(rsq_pick[ph], 32767, 1);
				2: set_config(rsq_pick[ph], $urandom_range(1, 300), $urandom_range(1, 300));
				default: set_config(rsq_pick[ph], $urandom_range(0, 32767),
					$urandom_range(0, 32767));
			endcase
			sender_steady = (ph == 2);
			for (int i = 0; i < 85; i++) begin
				if ($urandom_range(0, 99) < 55) begin
					pick_centre(r, c);
					send_item(KIND_EVAL, r, c, ELEV_W'($urandom()),
						1'($urandom_range(0, 1)));
				end else begin
					pick_cell(r, c);
					send_item(KIND_WRITE, r, c, terrain_height(r, c), terrain_known());
				end
			end
			sender_steady = 1'b0;
		end
	endtask

	// Receiver: stall pattern, long hold-off and result check
	always @(posedge clk or negedge arst_n) begin
		window_result_t exp_res;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
			stall_phase <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing expected: row %0d col %0d", out_row, out_col);
					errors++;
				end else begin
					exp_res = pending_results.pop_front();
					if (out_row !== exp_res.r) begin
						$error("out_row: expected %0d, got %0d", exp_res.r, out_row);
						errors++;
					end
					if (out_col !== exp_res.c) begin
						$error("out_col: expected %0d, got %0d", exp_res.c, out_col);
						errors++;
					end
					if (step_ratio !== exp_res.step) begin
						$error("step_ratio: expected %0d, got %0d", exp_res.step, step_ratio);
						errors++;
					end
					if (drop_ratio !== exp_res.drop) begin
						$error("drop_ratio: expected %0d, got %0d", exp_res.drop, drop_ratio);
						errors++;
					end
					if (result_valid !== exp_res.known) begin
						$error("result_valid: expected %0d, got %0d", exp_res.known,
							result_valid);
						errors++;
					end
				end
			end
			// pick a new stall pattern now and then
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(50, 800);
			end else begin
				mode_left <= mode_left - 1;
			end
			stall_phase <= stall_phase + 1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= (stall_phase % 7) < 3;
				endcase
			end
		end
	end

	initial begin
		clk = 1'b0;
		errors = 0;
		cycles = 0;
		hold_left = 0;
		burst_left = 0;
		sender_steady = 1'b0;
		shadow_rsq = 1;
		shadow_step_lim = 10;
		shadow_drop_lim = 10;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RADIUS_SQ;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_WRITE;
		row = '0;
		col = '0;
		elevation = '0;
		elevation_valid = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_fill_grid();
		test_directed();
		test_backpressure();
		test_random();

		wait_drained();
		repeat (EVAL_LATENCY) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("elevation_step_drop_window_top test passed");
		end else begin
			if (pending_results.size() != 0)
				$error("%0d expected results never arrived", pending_results.size());
			$display("elevation_step_drop_window_top test failed");
		end
		$finish;
	end

endmodule

[elevation_step_drop_window_top.f]
+incdir+rtl
rtl/esdw_pkg.sv
rtl/esdw_ram.sv
rtl/esdw_div.sv
rtl/elevation_step_drop_window_top.sv
rtl/esdw_checker.sv
tb/sv/elevation_step_drop_window_top_tb.sv
